// File: src/hci_pkg.sv
// Shared constants for the Hermite cubic interpolator: widths, mode codes and register indexes.
package hci_pkg;

  // Default sample and fraction widths.
  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int FRACTION_WIDTH_DEF = 16;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int MODE_W      = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TENSION = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BIAS    = 2'd2;

  // Interpolation modes; the unused code behaves as Hermite.
  localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CUBIC   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HERMITE = 2'd2;

  // Internal fixed-point formats.
  localparam int COEF_W     = 17;  // signed Q2.14 coefficients 1+b, 1-b, 1-t
  localparam int POW_W      = 17;  // unsigned Q1.16 powers of the fraction
  localparam int WEIGHT_W   = 20;  // signed Q.16 Hermite basis weights
  localparam int POW_SHIFT  = 16;  // fraction bits of the powers
  localparam int M_SHIFT    = 21;  // Q.14 * Q.14 / 2 brought to Q.8 slopes
  localparam int HERM_SHIFT = 24;  // fraction bits of the Hermite sum

  localparam logic signed [COEF_W-1:0]   Q14_ONE = 17'sd16384;
  localparam logic signed [WEIGHT_W-1:0] Q16_ONE = 20'sd65536;

endpackage

// File: src/hermite_cubic_interpolator_unit.sv
// An item accepted on the slave side passes through stages 1 to 6 to the master side.
// Throughput: one item per cycle; each of the six register stages holds one item and moves on.
// The rate is set by the slowest stage, a multiply of up to about 35 by 17 bits plus an add.
// A stalled output stage holds its item while earlier stages keep filling any empty slot.
// Reset (rst, synchronous, active high) empties the pipeline and loads mode Hermite,
// tension 0 and bias 0.
module hermite_cubic_interpolator_unit #(
  parameter int SAMPLE_WIDTH   = hci_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRACTION_WIDTH = hci_pkg::FRACTION_WIDTH_DEF,
  localparam int IN_W  = ((4 * SAMPLE_WIDTH + FRACTION_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input items. tdata from bit 0 up: sample_before, sample_start, sample_end,
  // sample_after, fraction, then zero fill.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_W-1:0]                 s_axis_tdata,
  // Result items. tdata from bit 0 up: interp_value, then zero fill.
  // tuser: saturated.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [OUT_W-1:0]                m_axis_tdata,
  output logic [0:0]                      m_axis_tuser,
  // Configuration writes.
  input  logic                            cfg_wr_en,
  input  logic [hci_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hci_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int FW = FRACTION_WIDTH;
  localparam int KW = hci_pkg::COEF_W;
  localparam int UW = hci_pkg::POW_W;
  localparam int HW = hci_pkg::WEIGHT_W;
  localparam int PS = hci_pkg::POW_SHIFT;
  localparam int MS = hci_pkg::M_SHIFT;
  localparam int HS = hci_pkg::HERM_SHIFT;

  // Widths of the intermediate values, each just wide enough for its range.
  localparam int DW   = SW + 1;          // neighbor differences
  localparam int AW   = SW + 3;          // cubic coefficients
  localparam int PRW  = DW + KW;         // difference times bias coefficient
  localparam int PW   = PRW + 1;         // biased slope sums
  localparam int PTW  = PW + KW;         // slope sum times tension coefficient
  localparam int MW   = PTW - MS;        // Q.8 slopes
  localparam int UUW  = 2 * UW;          // square of a power
  localparam int CPW  = AW + UW + 1;     // cubic coefficient times power
  localparam int CUBW = SW + 24;         // cubic sum at Q.16
  localparam int LPW  = DW + FW + 1;     // linear product
  localparam int LINW = SW + FW + 3;     // linear sum at Q.F
  localparam int HYPW = HW + SW;         // weight times sample
  localparam int HYW  = HYPW + 1;
  localparam int HMPW = HW + MW;         // weight times slope
  localparam int HMW  = HMPW + 1;
  localparam int YSH  = HS - PS;         // aligns the sample terms with the slope terms
  localparam int HACW = HMW + 1;         // Hermite sum at Q.24
  localparam int VALW = HACW - HS;       // widest rounded value
  localparam int CVW  = CUBW - PS;
  localparam int LVW  = LINW - FW;

  localparam logic [UUW-1:0]         POW_HALF = UUW'(1) << (PS - 1);
  localparam logic signed [PTW-1:0]  M_HALF   = PTW'(1) << (MS - 1);
  localparam logic signed [HACW-1:0] H_HALF   = HACW'(1) << (HS - 1);
  localparam logic signed [CUBW-1:0] C_HALF   = CUBW'(1) << (PS - 1);
  localparam logic signed [LINW-1:0] L_HALF   = LINW'(1) << (FW - 1);
  localparam logic signed [VALW-1:0] HI_LIM   = {{(VALW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [VALW-1:0] LO_LIM   = ~HI_LIM;

  localparam int NSTG = 6;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes to an index past the register list are
  // dropped. The coefficients derived from them are plain logic, so the user must change the
  // registers only while no item is in flight; the block does not enforce this.
  // ---------------------------------------------------------------------------
  logic [hci_pkg::MODE_W-1:0] mode;
  logic signed [15:0]         tension;
  logic signed [15:0]         bias;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= hci_pkg::MODE_HERMITE;
      tension <= '0;
      bias    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hci_pkg::REG_MODE:    mode    <= cfg_data[hci_pkg::MODE_W-1:0];
        hci_pkg::REG_TENSION: tension <= cfg_data;
        hci_pkg::REG_BIAS:    bias    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [KW-1:0] bias_e, tension_e;
  logic signed [KW-1:0] b1, b2, tt;

  assign bias_e    = KW'(bias);
  assign tension_e = KW'(tension);
  assign b1        = hci_pkg::Q14_ONE + bias_e;
  assign b2        = hci_pkg::Q14_ONE - bias_e;
  assign tt        = hci_pkg::Q14_ONE - tension_e;

  // ---------------------------------------------------------------------------
  // Stage handshake. Each stage loads when it is empty or when the stage after
  // it moves on, so bubbles are squeezed out and a stall at the output only
  // holds back the stages that are actually full.
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  always_comb begin
    en[5] = !vld[5] || m_axis_tready;
    en[4] = !vld[4] || en[5];
    en[3] = !vld[3] || en[4];
    en[2] = !vld[2] || en[3];
    en[1] = !vld[1] || en[2];
    en[0] = !vld[0] || en[1];
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_axis_tvalid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
      if (en[4]) vld[4] <= vld[3];
      if (en[5]) vld[5] <= vld[4];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: unpack, neighbor differences, cubic coefficients and the fraction
  // brought to Q.16 (rounded when the fraction is wider than 16 bits).
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] y0_i, y1_i, y2_i, y3_i;
  logic [FW-1:0]        mu_i;
  logic signed [DW-1:0] d10_next, d21_next, d32_next;
  logic signed [AW-1:0] a0_next, a1_next, a2_next;
  logic [UW-1:0]        u_next;

  assign y0_i = s_axis_tdata[SW-1:0];
  assign y1_i = s_axis_tdata[2*SW-1:SW];
  assign y2_i = s_axis_tdata[3*SW-1:2*SW];
  assign y3_i = s_axis_tdata[4*SW-1:3*SW];
  assign mu_i = s_axis_tdata[4*SW+FW-1:4*SW];

  assign d10_next = y1_i - y0_i;
  assign d21_next = y2_i - y1_i;
  assign d32_next = y3_i - y2_i;
  assign a0_next  = y3_i - y2_i - y0_i + y1_i;
  assign a1_next  = y0_i + y0_i - y1_i - y1_i - y3_i + y2_i;
  assign a2_next  = y2_i - y0_i;

  generate
    if (FW > PS) begin : g_mu_round
      localparam int RSH = FW - PS;
      logic [FW:0] mu_r;
      assign mu_r   = {1'b0, mu_i} + ((FW + 1)'(1) << (RSH - 1));
      assign u_next = UW'(mu_r >> RSH);
    end else begin : g_mu_widen
      assign u_next = UW'({1'b0, mu_i}) << (PS - FW);
    end
  endgenerate

  logic signed [DW-1:0] s1_d10, s1_d21, s1_d32;
  logic signed [AW-1:0] s1_a0, s1_a1, s1_a2;
  logic [UW-1:0]        s1_u;
  logic signed [SW-1:0] s1_y1, s1_y2;
  logic [FW-1:0]        s1_mu;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_d10 <= d10_next;
      s1_d21 <= d21_next;
      s1_d32 <= d32_next;
      s1_a0  <= a0_next;
      s1_a1  <= a1_next;
      s1_a2  <= a2_next;
      s1_u   <= u_next;
      s1_y1  <= y1_i;
      s1_y2  <= y2_i;
      s1_mu  <= mu_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: biased slope sums, the square of the fraction, the linear result
  // at Q.F and the first cubic product.
  // ---------------------------------------------------------------------------
  logic signed [PRW-1:0] pr00, pr01, pr10, pr11;
  logic signed [PW-1:0]  p0_next, p1_next;
  logic [UUW-1:0]        uu2;
  logic [UW-1:0]         u2_next;
  logic signed [UW:0]    us1;
  logic signed [CPW-1:0] c2_next;
  logic signed [FW:0]    mus;
  logic signed [LPW-1:0] lin_prod;
  logic signed [SW+FW-1:0] lin_y1;
  logic signed [LINW-1:0]  lin_next;

  assign pr00    = s1_d10 * b1;
  assign pr01    = s1_d21 * b2;
  assign pr10    = s1_d21 * b1;
  assign pr11    = s1_d32 * b2;
  assign p0_next = pr00 + pr01;
  assign p1_next = pr10 + pr11;

  assign uu2     = s1_u * s1_u + POW_HALF;
  assign u2_next = uu2[PS+UW-1:PS];

  assign us1     = {1'b0, s1_u};
  assign c2_next = s1_a2 * us1;

  assign mus      = {1'b0, s1_mu};
  assign lin_prod = s1_d21 * mus;
  assign lin_y1   = {s1_y1, {FW{1'b0}}};
  assign lin_next = lin_y1 + lin_prod;

  logic signed [PW-1:0]   s2_p0, s2_p1;
  logic [UW-1:0]          s2_u2, s2_u;
  logic signed [AW-1:0]   s2_a0, s2_a1;
  logic signed [CPW-1:0]  s2_c2;
  logic signed [SW-1:0]   s2_y1, s2_y2;
  logic signed [LINW-1:0] s2_lin;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_p0  <= p0_next;
      s2_p1  <= p1_next;
      s2_u2  <= u2_next;
      s2_u   <= s1_u;
      s2_a0  <= s1_a0;
      s2_a1  <= s1_a1;
      s2_c2  <= c2_next;
      s2_y1  <= s1_y1;
      s2_y2  <= s1_y2;
      s2_lin <= lin_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: slopes scaled by the tension and rounded to Q.8, the cube of the
  // fraction, and the second cubic product.
  // ---------------------------------------------------------------------------
  logic signed [PTW-1:0]  pt0, pt1, mr0, mr1;
  logic signed [MW-1:0]   m0_next, m1_next;
  logic [UUW-1:0]         uu3;
  logic [UW-1:0]          u3_next;
  logic signed [UW:0]     u2s;
  logic signed [CPW-1:0]  c1_next;
  logic signed [SW+PS-1:0] y1h;
  logic signed [CUBW-1:0] cs_next;

  assign pt0     = s2_p0 * tt;
  assign pt1     = s2_p1 * tt;
  assign mr0     = pt0 + M_HALF;
  assign mr1     = pt1 + M_HALF;
  assign m0_next = mr0[PTW-1:MS];
  assign m1_next = mr1[PTW-1:MS];

  assign uu3     = s2_u2 * s2_u + POW_HALF;
  assign u3_next = uu3[PS+UW-1:PS];

  assign u2s     = {1'b0, s2_u2};
  assign c1_next = s2_a1 * u2s;
  assign y1h     = {s2_y1, {PS{1'b0}}};
  assign cs_next = s2_c2 + y1h;

  logic signed [MW-1:0]   s3_m0, s3_m1;
  logic [UW-1:0]          s3_u3, s3_u2, s3_u;
  logic signed [AW-1:0]   s3_a0;
  logic signed [CPW-1:0]  s3_c1;
  logic signed [CUBW-1:0] s3_cs;
  logic signed [SW-1:0]   s3_y1, s3_y2;
  logic signed [LINW-1:0] s3_lin;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_m0  <= m0_next;
      s3_m1  <= m1_next;
      s3_u3  <= u3_next;
      s3_u2  <= s2_u2;
      s3_u   <= s2_u;
      s3_a0  <= s2_a0;
      s3_c1  <= c1_next;
      s3_cs  <= cs_next;
      s3_y1  <= s2_y1;
      s3_y2  <= s2_y2;
      s3_lin <= s2_lin;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: Hermite basis weights and the last cubic product.
  // ---------------------------------------------------------------------------
  logic signed [HW-1:0]   w1, w2, w3;
  logic signed [HW-1:0]   h00_next, h10_next, h11_next, h01_next;
  logic signed [UW:0]     u3s;
  logic signed [CPW-1:0]  c0_next;
  logic signed [CUBW-1:0] cs2_next;

  assign w1 = {{(HW - UW){1'b0}}, s3_u};
  assign w2 = {{(HW - UW){1'b0}}, s3_u2};
  assign w3 = {{(HW - UW){1'b0}}, s3_u3};

  assign h00_next = w3 + w3 - w2 - w2 - w2 + hci_pkg::Q16_ONE;
  assign h10_next = w3 - w2 - w2 + w1;
  assign h11_next = w3 - w2;
  assign h01_next = w2 + w2 + w2 - w3 - w3;

  assign u3s      = {1'b0, s3_u3};
  assign c0_next  = s3_a0 * u3s;
  assign cs2_next = s3_cs + s3_c1;

  logic signed [HW-1:0]   s4_h00, s4_h10, s4_h11, s4_h01;
  logic signed [CPW-1:0]  s4_c0;
  logic signed [CUBW-1:0] s4_cs;
  logic signed [MW-1:0]   s4_m0, s4_m1;
  logic signed [SW-1:0]   s4_y1, s4_y2;
  logic signed [LINW-1:0] s4_lin;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_h00 <= h00_next;
      s4_h10 <= h10_next;
      s4_h11 <= h11_next;
      s4_h01 <= h01_next;
      s4_c0  <= c0_next;
      s4_cs  <= cs2_next;
      s4_m0  <= s3_m0;
      s4_m1  <= s3_m1;
      s4_y1  <= s3_y1;
      s4_y2  <= s3_y2;
      s4_lin <= s3_lin;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: weighted samples and weighted slopes for Hermite, full cubic sum.
  // ---------------------------------------------------------------------------
  logic signed [HYPW-1:0] hyp0, hyp1;
  logic signed [HYW-1:0]  hy_next;
  logic signed [HMPW-1:0] hmp0, hmp1;
  logic signed [HMW-1:0]  hm_next;
  logic signed [CUBW-1:0] cub_next;

  assign hyp0     = s4_h00 * s4_y1;
  assign hyp1     = s4_h01 * s4_y2;
  assign hy_next  = hyp0 + hyp1;
  assign hmp0     = s4_h10 * s4_m0;
  assign hmp1     = s4_h11 * s4_m1;
  assign hm_next  = hmp0 + hmp1;
  assign cub_next = s4_cs + s4_c0;

  logic signed [HYW-1:0]  s5_hy;
  logic signed [HMW-1:0]  s5_hm;
  logic signed [CUBW-1:0] s5_cub;
  logic signed [LINW-1:0] s5_lin;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_hy  <= hy_next;
      s5_hm  <= hm_next;
      s5_cub <= cub_next;
      s5_lin <= s4_lin;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: round half up in each mode, pick the mode, clamp to the sample
  // range and flag the clamp. This is the output register.
  // ---------------------------------------------------------------------------
  logic signed [HYW+YSH-1:0] hy_sh;
  logic signed [HACW-1:0]    hacc;
  logic signed [CUBW-1:0]    cacc;
  logic signed [LINW-1:0]    lacc;
  logic signed [VALW-1:0]    v_herm;
  logic signed [CVW-1:0]     v_cub;
  logic signed [LVW-1:0]     v_lin;
  logic signed [VALW-1:0]    val;
  logic                      sat_next;
  logic [SW-1:0]             value_next;

  assign hy_sh  = {s5_hy, {YSH{1'b0}}};
  assign hacc   = hy_sh + s5_hm + H_HALF;
  assign cacc   = s5_cub + C_HALF;
  assign lacc   = s5_lin + L_HALF;
  assign v_herm = hacc[HACW-1:HS];
  assign v_cub  = cacc[CUBW-1:PS];
  assign v_lin  = lacc[LINW-1:FW];

  always_comb begin
    unique case (mode)
      hci_pkg::MODE_LINEAR: val = v_lin;
      hci_pkg::MODE_CUBIC:  val = v_cub;
      default:              val = v_herm;
    endcase
    sat_next   = 1'b0;
    value_next = val[SW-1:0];
    if (val > HI_LIM) begin
      sat_next   = 1'b1;
      value_next = HI_LIM[SW-1:0];
    end else if (val < LO_LIM) begin
      sat_next   = 1'b1;
      value_next = LO_LIM[SW-1:0];
    end
  end

  logic [SW-1:0] out_value;
  logic          out_sat;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      out_value <= value_next;
      out_sat   <= sat_next;
    end
  end

  assign m_axis_tvalid   = vld[5];
  assign m_axis_tdata    = OUT_W'(out_value);
  assign m_axis_tuser[0] = out_sat;

endmodule

// File: src/hci_checker.sv
// Port-level checks for the Hermite cubic interpolator, bound to its top level.
module hci_checker #(
  parameter int SAMPLE_WIDTH   = hci_pkg::SAMPLE_WIDTH_DEF,
  localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [OUT_W-1:0]                m_axis_tdata,
  input logic [0:0]                      m_axis_tuser
);

  localparam logic [SAMPLE_WIDTH-1:0] HI_VAL = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] LO_VAL = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

  // A held result keeps its value and flag.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A saturated result sits at one end of the sample range.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[SAMPLE_WIDTH-1:0] == HI_VAL) || (m_axis_tdata[SAMPLE_WIDTH-1:0] == LO_VAL))
    else $error("saturated result not at a range limit");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // With the output side taking items, the input side is never held off.
  a_full_rate: assert property (@(posedge clk) m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output ready");

endmodule

bind hermite_cubic_interpolator_unit hci_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_hci_checker (.*);

// File: dv/testbench.sv
// Self-checking stream testbench for the four-point linear, cubic and Hermite sample interpolator.
`timescale 1ns / 100ps

module testbench;

  // The block runs at its default widths; the predictor below assumes them.
  localparam int SW         = hci_pkg::SAMPLE_WIDTH_DEF;
  localparam int FW         = hci_pkg::FRACTION_WIDTH_DEF;
  localparam int IW         = hci_pkg::CFG_INDEX_W;
  localparam int DW         = hci_pkg::CFG_DATA_W;
  localparam int MW         = hci_pkg::MODE_W;
  localparam int IN_BITS    = ((4 * SW + FW + 7) / 8) * 8;
  localparam int OUT_BITS   = ((SW + 7) / 8) * 8;
  // Base of the final wait after the last result; a little slack goes on top.
  localparam int PIPE_DEPTH = 5;
  // Generous limit for long gaps and long stalls on both sides over about
  // 2000 items.
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int RANDOM_PHASES   = 13;

  // Register index past the end of the list; writes to it must be ignored.
  localparam logic [IW-1:0] REG_UNUSED  = 2'd3;
  // Mode code with no meaning of its own; the block treats it as Hermite.
  localparam logic [MW-1:0] MODE_UNUSED = 2'd3;

  localparam logic signed [SW-1:0] S_MIN = -16'sd32768;
  localparam logic signed [SW-1:0] S_MAX = 16'sd32767;
  localparam logic [FW-1:0] MU_HALF = 16'd32768;
  localparam logic [FW-1:0] MU_TOP  = 16'd65535;

  // One input item: four neighboring samples and the position between the middle two.
  typedef struct {
    logic signed [SW-1:0] sample_before;
    logic signed [SW-1:0] sample_start;
    logic signed [SW-1:0] sample_end;
    logic signed [SW-1:0] sample_after;
    logic [FW-1:0]        fraction;
  } sample_item_t;

  // One result item.
  typedef struct {
    logic signed [SW-1:0] interp_value;
    logic                 saturated;
  } interp_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // tdata from bit 0 up: sample_before, sample_start, sample_end, sample_after, fraction.
  logic [IN_BITS-1:0]     s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // tdata from bit 0 up: interp_value.
  logic [OUT_BITS-1:0]    m_axis_tdata;
  // tuser: saturated.
  logic [0:0]             m_axis_tuser;
  logic                   cfg_wr_en = 1'b0;
  logic [IW-1:0]          cfg_index = '0;
  logic [DW-1:0]          cfg_data = '0;

  // Our own copy of the configuration registers, loaded with the reset values.
  logic [MW-1:0]        cur_mode    = hci_pkg::MODE_HERMITE;
  logic signed [15:0]   cur_tension = '0;
  logic signed [15:0]   cur_bias    = '0;

  // Results that accepted items have yet to produce, oldest first.
  interp_out_t interp_queue[$];

  int          fail_count  = 0;
  int unsigned cycle_count = 0;
  // Whether each side currently inserts idle cycles; tests turn these on and off
  // so that runs with and without gaps both occur.
  bit          sender_idles   = 1'b0;
  bit          receiver_idles = 1'b0;
  int          stall_left     = 0;

  hermite_cubic_interpolator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Guard against a hung handshake or results that never arrive.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // floor((x + 2^(n-1)) / 2^n): round half up, on a 64-bit signed value.
  function automatic longint round_half_up(longint x, int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // Computes the result of one item from the current register copy.
  // Everything is exact integer arithmetic in 64 bits, which holds every
  // intermediate product at these widths without overflow.
  function automatic interp_out_t interpolate(sample_item_t it);
    longint y0, y1, y2, y3, mu, mu2, mu3, acc, val;
    longint a0, a1, a2;
    longint t, b, b1, b2, tt, p0, p1, m0, m1, h00, h10, h11, h01;
    interp_out_t res;
    y0  = it.sample_before;
    y1  = it.sample_start;
    y2  = it.sample_end;
    y3  = it.sample_after;
    mu  = it.fraction;
    // Powers of the fraction, each rounded back to Q.16.
    mu2 = (mu * mu + 32768) >>> hci_pkg::POW_SHIFT;
    mu3 = (mu2 * mu + 32768) >>> hci_pkg::POW_SHIFT;
    if (cur_mode == hci_pkg::MODE_LINEAR) begin
      acc = (y1 <<< FW) + (y2 - y1) * mu;
      val = round_half_up(acc, FW);
    end else if (cur_mode == hci_pkg::MODE_CUBIC) begin
      a0  = y3 - y2 - y0 + y1;
      a1  = y0 - y1 - a0;
      a2  = y2 - y0;
      acc = a0 * mu3 + a1 * mu2 + a2 * mu + (y1 <<< hci_pkg::POW_SHIFT);
      val = round_half_up(acc, hci_pkg::POW_SHIFT);
    end else begin
      // Hermite, also taken by the unused mode code.
      t   = cur_tension;
      b   = cur_bias;
      b1  = 16384 + b;
      b2  = 16384 - b;
      tt  = 16384 - t;
      p0  = (y1 - y0) * b1 + (y2 - y1) * b2;
      p1  = (y2 - y1) * b1 + (y3 - y2) * b2;
      // Slopes at Q.8, halved by the extra shift bit.
      m0  = round_half_up(p0 * tt, hci_pkg::M_SHIFT);
      m1  = round_half_up(p1 * tt, hci_pkg::M_SHIFT);
      h00 = 2 * mu3 - 3 * mu2 + 65536;
      h10 = mu3 - 2 * mu2 + mu;
      h11 = mu3 - mu2;
      h01 = -2 * mu3 + 3 * mu2;
      acc = (h00 * y1 + h01 * y2) * 256 + h10 * m0 + h11 * m1;
      val = round_half_up(acc, hci_pkg::HERM_SHIFT);
    end
    res.saturated = 1'b0;
    if (val > 32767) begin
      val = 32767;
      res.saturated = 1'b1;
    end else if (val < -32768) begin
      val = -32768;
      res.saturated = 1'b1;
    end
    res.interp_value = val[SW-1:0];
    return res;
  endfunction

  // Idle length: mostly short, now and then a long one.
  function automatic int pick_pause();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic sample_item_t make_item(logic signed [SW-1:0] y0, logic signed [SW-1:0] y1,
                                             logic signed [SW-1:0] y2, logic signed [SW-1:0] y3,
                                             logic [FW-1:0] mu);
    sample_item_t it;
    it.sample_before = y0;
    it.sample_start  = y1;
    it.sample_end    = y2;
    it.sample_after  = y3;
    it.fraction      = mu;
    return it;
  endfunction

  // Sends one item: an optional gap with tvalid low, then tvalid high until the
  // block accepts it. tvalid is left high so back-to-back items need no toggle.
  task automatic send_item(sample_item_t it);
    int gap;
    gap = (sender_idles && $urandom_range(0, 99) < 35) ? pick_pause() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.fraction, it.sample_after, it.sample_end, it.sample_start,
                      it.sample_before};
    do @(posedge clk); while (!s_axis_tready);
    interp_queue.push_back(interpolate(it));
  endtask

  // Stops sending and waits until every accepted item has produced its result.
  // The wait always passes a clock edge, so the lowered tvalid is never raised again
  // in the same time step.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (interp_queue.size() != 0);
  endtask

  // One register write; only called while the block is empty.
  task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      hci_pkg::REG_MODE:    cur_mode    = value[MW-1:0];
      hci_pkg::REG_TENSION: cur_tension = value;
      hci_pkg::REG_BIAS:    cur_bias    = value;
      default: ;
    endcase
  endtask

  // Mode word with random bits above the mode field, which the block must drop.
  function automatic logic [DW-1:0] mode_word(logic [MW-1:0] mode);
    logic [DW-1:0] w;
    w = DW'($urandom_range(0, 65535));
    w[MW-1:0] = mode;
    return w;
  endfunction

  // Tension or bias: the ends of the range, zero or one in Q.14 two thirds of the time, random otherwise.
  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 16'sd0;
      1: return S_MIN;
      2: return S_MAX;
      3: return 16'sd16384;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic signed [SW-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      3: return -16'sd1;
      default: return SW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic signed [SW-1:0] clamp_sample(int v);
    if (v > 32767) return S_MAX;
    if (v < -32768) return S_MIN;
    return SW'(v);
  endfunction

  // Random item of one of several shapes: fully random, smooth ramps as a real
  // signal would give, extreme values, special fractions, and sharp swings that
  // push the cubic and Hermite curves past the sample range.
  function automatic sample_item_t random_item();
    sample_item_t it;
    int base, slope;
    logic signed [SW-1:0] hi_val;
    it.sample_before = SW'($urandom_range(0, 65535));
    it.sample_start  = SW'($urandom_range(0, 65535));
    it.sample_end    = SW'($urandom_range(0, 65535));
    it.sample_after  = SW'($urandom_range(0, 65535));
    it.fraction      = FW'($urandom_range(0, 65535));
    case ($urandom_range(0, 9)) inside
      [4:6]: begin
        base  = int'($urandom_range(0, 65535)) - 32768;
        slope = int'($urandom_range(0, 4000)) - 2000;
        it.sample_before = clamp_sample(base);
        it.sample_start  = clamp_sample(base + slope + int'($urandom_range(0, 64)) - 32);
        it.sample_end    = clamp_sample(base + 2 * slope + int'($urandom_range(0, 64)) - 32);
        it.sample_after  = clamp_sample(base + 3 * slope);
      end
      7: begin
        it.sample_before = pick_extreme();
        it.sample_start  = pick_extreme();
        it.sample_end    = pick_extreme();
        it.sample_after  = pick_extreme();
      end
      8: begin
        case ($urandom_range(0, 3))
          0: it.fraction = '0;
          1: it.fraction = 16'd1;
          2: it.fraction = MU_HALF;
          default: it.fraction = MU_TOP;
        endcase
      end
      9: begin
        hi_val = $urandom_range(0, 1) ? S_MAX : S_MIN;
        it.sample_before = -hi_val - 16'sd1;
        it.sample_start  = hi_val;
        it.sample_end    = hi_val;
        it.sample_after  = -hi_val - 16'sd1;
      end
      default: ;
    endcase
    return it;
  endfunction

  // Result side: drives tready with random stalls and checks every result
  // against the oldest pending prediction.
  always @(posedge clk) begin : result_check
    interp_out_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (interp_queue.size() == 0) begin
          $error("result with no item pending: interp_value %0d",
                 $signed(m_axis_tdata[SW-1:0]));
          fail_count++;
        end else begin
          want = interp_queue.pop_front();
          if (m_axis_tdata[SW-1:0] !== want.interp_value) begin
            $error("interp_value: expected %0d, actual %0d", want.interp_value,
                   $signed(m_axis_tdata[SW-1:0]));
            fail_count++;
          end
          if (m_axis_tuser[0] !== want.saturated) begin
            $error("saturated: expected %0b, actual %0b", want.saturated, m_axis_tuser[0]);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (receiver_idles && $urandom_range(0, 99) < 25) stall_left = pick_pause();
      end
    end
  end

  // The registers are not written here, so the reset values (Hermite, tension
  // and bias zero) must be in effect.
  task automatic test_reset_values();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    send_item(make_item(16'sd0, 16'sd1000, 16'sd3000, 16'sd0, MU_HALF));
    send_item(make_item(S_MIN, S_MAX, S_MIN, S_MAX, MU_TOP));
    send_item(make_item(-16'sd500, 16'sd200, -16'sd900, 16'sd4000, 16'd12345));
    wait_for_results();
  endtask

  // Linear mode: ends of the fraction, the half-way rounding point in both
  // directions, and the widest step between the middle samples.
  task automatic test_linear();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    write_reg(hci_pkg::REG_MODE, mode_word(hci_pkg::MODE_LINEAR));
    send_item(make_item(S_MAX, S_MIN, S_MAX, S_MIN, '0));
    send_item(make_item(S_MAX, S_MIN, S_MAX, S_MIN, MU_TOP));
    send_item(make_item(16'sd0, 16'sd0, 16'sd1, 16'sd0, MU_HALF));
    send_item(make_item(16'sd0, 16'sd0, -16'sd1, 16'sd0, MU_HALF));
    send_item(make_item(S_MIN, S_MAX, S_MAX, S_MAX, MU_TOP));
    wait_for_results();
  endtask

  // Cubic mode: overshoot past both ends of the range, and the fraction ends.
  task automatic test_cubic();
    write_reg(hci_pkg::REG_MODE, mode_word(hci_pkg::MODE_CUBIC));
    send_item(make_item(S_MIN, S_MAX, S_MAX, S_MIN, MU_HALF));
    send_item(make_item(S_MAX, S_MIN, S_MIN, S_MAX, MU_HALF));
    send_item(make_item(16'sd1234, -16'sd77, 16'sd9000, -16'sd3, '0));
    send_item(make_item(16'sd1234, -16'sd77, 16'sd9000, -16'sd3, MU_TOP));
    wait_for_results();
  endtask

  // Hermite mode: tension and bias at their extremes, the unused mode code,
  // and a write to an index past the register list.
  task automatic test_hermite();
    write_reg(hci_pkg::REG_MODE, mode_word(hci_pkg::MODE_HERMITE));
    write_reg(hci_pkg::REG_TENSION, S_MIN);
    write_reg(hci_pkg::REG_BIAS, S_MAX);
    send_item(make_item(S_MIN, S_MAX, S_MIN, S_MAX, MU_HALF));
    send_item(make_item(S_MAX, S_MIN, S_MAX, S_MIN, 16'd16384));
    send_item(make_item(S_MIN, S_MAX, S_MAX, S_MIN, MU_TOP));
    wait_for_results();
    write_reg(hci_pkg::REG_TENSION, S_MAX);
    write_reg(hci_pkg::REG_BIAS, S_MIN);
    send_item(make_item(S_MIN, S_MAX, S_MIN, S_MAX, MU_HALF));
    send_item(make_item(16'sd100, -16'sd20000, 16'sd30000, S_MIN, 16'd49152));
    wait_for_results();
    // Unused mode code behaves as Hermite.
    write_reg(hci_pkg::REG_MODE, mode_word(MODE_UNUSED));
    send_item(make_item(S_MAX, S_MIN, S_MAX, S_MIN, MU_HALF));
    send_item(make_item(-16'sd1, 16'sd0, 16'sd1, 16'sd2, 16'd1));
    wait_for_results();
    // A write to an index past the list must leave every register unchanged.
    write_reg(REG_UNUSED, {DW{1'b0}});
    send_item(make_item(S_MAX, S_MIN, S_MAX, S_MIN, MU_HALF));
    send_item(make_item(S_MIN, S_MAX, S_MAX, S_MIN, 16'd40000));
    wait_for_results();
  endtask

  // Random stream in phases; each phase starts with the block drained, a new
  // register setting and a new idling pattern. Modes go through every code
  // first, then are picked at random.
  task automatic test_random_stream();
    logic [MW-1:0] mode_order [4];
    logic [MW-1:0] mode_sel;
    int phase, n;
    mode_order = '{hci_pkg::MODE_LINEAR, hci_pkg::MODE_CUBIC, hci_pkg::MODE_HERMITE,
                   MODE_UNUSED};
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      mode_sel = (phase < 4) ? mode_order[phase] : mode_order[$urandom_range(0, 3)];
      write_reg(hci_pkg::REG_MODE, mode_word(mode_sel));
      write_reg(hci_pkg::REG_TENSION, pick_coef());
      write_reg(hci_pkg::REG_BIAS, pick_coef());
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, DW'($urandom_range(0, 65535)));
      sender_idles   = ($urandom_range(0, 9) < 7);
      receiver_idles = ($urandom_range(0, 9) < 7);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Now and then let the pipeline run completely empty mid-phase.
        if ($urandom_range(0, 149) == 0) wait_for_results();
        send_item(random_item());
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_linear();
    test_cubic();
    test_hermite();
    test_random_stream();
    wait_for_results();
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
